>>> hdl/bhm_pkg.sv
// Types, codes and the 32-bit popcount shared by the best-match ratio test block.
// No dependencies.
`default_nettype none
package bhm_pkg;

    localparam int DESC_W  = 64;
    localparam int IDX_W   = 10;
    localparam int LVL_W   = 3;
    localparam int TLVL_W  = 4;
    localparam int DIST_W  = 9;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;

    localparam logic [DIST_W-1:0] DIST_NONE = 9'd256;
    localparam logic [TLVL_W-1:0] LVL_NONE  = 4'd15;
    localparam logic [CFG_W-1:0]  THR_RESET   = 9'd95;
    localparam logic [CFG_W-1:0]  RATIO_RESET = 9'd230;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_CAND  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_ACCEPT_THRESHOLD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NN_RATIO         = 2'd1;

    typedef enum logic [1:0] {
        ST_MATCH = 2'd0,
        ST_FAR   = 2'd1,
        ST_RATIO = 2'd2
    } status_t;

    typedef struct packed {
        logic              func;
        logic [DESC_W-1:0] desc_w0;
        logic [DESC_W-1:0] desc_w1;
        logic [DESC_W-1:0] desc_w2;
        logic [DESC_W-1:0] desc_w3;
        logic [IDX_W-1:0]  cand_index;
        logic [LVL_W-1:0]  cand_level;
        logic              cand_excluded;
        logic              last;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  match_index;
        logic [DIST_W-1:0] best_distance;
        logic [DIST_W-1:0] second_distance;
    } res_t;

    // distance stage -> tracking stage
    typedef struct packed {
        logic              valid;
        logic              func;
        logic              excluded;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [LVL_W-1:0]  lvl;
        logic [DIST_W-1:0] hdist;
    } dist_t;

    // tracking stage -> judge stage, captured on the last candidate
    typedef struct packed {
        logic              valid;
        logic              none;
        logic              same_lvl;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
    } snap_t;

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        v1 = v - ((v >> 1) & 32'h5555_5555);
        v2 = (v1 & 32'h3333_3333) + ((v1 >> 2) & 32'h3333_3333);
        v3 = (v2 + (v2 >> 4)) & 32'h0F0F_0F0F;
        return 6'(v3[7:0]) + 6'(v3[15:8]) + 6'(v3[23:16]) + 6'(v3[31:24]);
    endfunction

endpackage
`default_nettype wire

>>> hdl/hamming_best_match_ratio_test.sv
// Throughput: one request per cycle; the popcount, best-pair update and ratio test
// each sit in their own register stage. The pipeline holds only when a second result
// reaches the snapshot stage while the result register is still waiting.
// Reset (rst_n, async): valid bits cleared, query zeroed, tracking cleared,
// accept_threshold = 95, nn_ratio = 230.
`default_nettype none
module hamming_best_match_ratio_test (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire bhm_pkg::req_t              req,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output bhm_pkg::res_t                   res,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bhm_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [bhm_pkg::CFG_W-1:0]  cfg_data
);

    logic [bhm_pkg::CFG_W-1:0] thr_reg;
    logic [bhm_pkg::CFG_W-1:0] ratio_reg;
    logic                      adv;
    bhm_pkg::dist_t            ham;
    bhm_pkg::snap_t            snap;

    assign adv       = !(snap.valid && res_valid && !res_ready);
    assign req_ready = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= bhm_pkg::THR_RESET;
            ratio_reg <= bhm_pkg::RATIO_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bhm_pkg::CFG_ACCEPT_THRESHOLD: thr_reg   <= cfg_data;
                bhm_pkg::CFG_NN_RATIO:         ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bhm_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req),
        .ham       (ham)
    );

    bhm_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .ham   (ham),
        .snap  (snap)
    );

    bhm_judge u_judge (
        .clk              (clk),
        .rst_n            (rst_n),
        .snap             (snap),
        .accept_threshold (thr_reg),
        .nn_ratio         (ratio_reg),
        .res_ready        (res_ready),
        .res_valid        (res_valid),
        .res              (res)
    );

endmodule
`default_nettype wire

>>> hdl/bhm_dist.sv
// Request register, query descriptor store and 256-bit Hamming distance stage.
// Depends on bhm_pkg.
`default_nettype none
module bhm_dist (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          req_valid,
    input  wire bhm_pkg::req_t req,
    output bhm_pkg::dist_t     ham
);

    logic                       in_valid_reg;
    bhm_pkg::req_t              in_reg;
    logic [4*bhm_pkg::DESC_W-1:0] query_reg;
    logic [4*bhm_pkg::DESC_W-1:0] cand_bits;
    logic [4*bhm_pkg::DESC_W-1:0] diff;
    logic [bhm_pkg::DIST_W-1:0] dist_next;
    bhm_pkg::dist_t             dist_reg;

    assign cand_bits = {in_reg.desc_w3, in_reg.desc_w2, in_reg.desc_w1, in_reg.desc_w0};
    assign diff      = cand_bits ^ query_reg;

    always_comb
    begin
        dist_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            dist_next = dist_next + bhm_pkg::DIST_W'(bhm_pkg::popcount32(diff[32*i +: 32]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg <= '0;
        end
        else if (adv && in_valid_reg && in_reg.func == bhm_pkg::FUNC_QUERY)
        begin
            query_reg <= cand_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
        end
        else if (adv)
        begin
            dist_reg.valid    <= in_valid_reg;
            dist_reg.func     <= in_reg.func;
            dist_reg.excluded <= in_reg.cand_excluded;
            dist_reg.last     <= in_reg.last;
            dist_reg.idx      <= in_reg.cand_index;
            dist_reg.lvl      <= in_reg.cand_level;
            dist_reg.hdist    <= dist_next;
        end
    end

    assign ham = dist_reg;

endmodule
`default_nettype wire

>>> hdl/bhm_track.sv
// Best and second-best tracking, and the snapshot taken on the last candidate.
// Depends on bhm_pkg.
`default_nettype none
module bhm_track (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire bhm_pkg::dist_t ham,
    output bhm_pkg::snap_t      snap
);

    logic [bhm_pkg::DIST_W-1:0] best_reg, best_next;
    logic [bhm_pkg::DIST_W-1:0] second_reg, second_next;
    logic [bhm_pkg::TLVL_W-1:0] best_lvl_reg, best_lvl_next;
    logic [bhm_pkg::TLVL_W-1:0] second_lvl_reg, second_lvl_next;
    logic [bhm_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic                       snap_valid_next;
    bhm_pkg::snap_t             snap_reg;
    logic [bhm_pkg::TLVL_W-1:0] cand_lvl;

    assign cand_lvl = bhm_pkg::TLVL_W'(ham.lvl);

    always_comb
    begin
        best_next       = best_reg;
        second_next     = second_reg;
        best_lvl_next   = best_lvl_reg;
        second_lvl_next = second_lvl_reg;
        best_idx_next   = best_idx_reg;
        if (ham.func == bhm_pkg::FUNC_QUERY)
        begin
            best_next       = bhm_pkg::DIST_NONE;
            second_next     = bhm_pkg::DIST_NONE;
            best_lvl_next   = bhm_pkg::LVL_NONE;
            second_lvl_next = bhm_pkg::LVL_NONE;
            best_idx_next   = '0;
        end
        else if (!ham.excluded)
        begin
            if (ham.hdist < best_reg)
            begin
                second_next     = best_reg;
                second_lvl_next = best_lvl_reg;
                best_next       = ham.hdist;
                best_lvl_next   = cand_lvl;
                best_idx_next   = ham.idx;
            end
            else if (ham.hdist < second_reg)
            begin
                second_next     = ham.hdist;
                second_lvl_next = cand_lvl;
            end
        end
    end

    assign snap_valid_next = ham.valid && ham.func == bhm_pkg::FUNC_CAND && ham.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg       <= bhm_pkg::DIST_NONE;
            second_reg     <= bhm_pkg::DIST_NONE;
            best_lvl_reg   <= bhm_pkg::LVL_NONE;
            second_lvl_reg <= bhm_pkg::LVL_NONE;
            best_idx_reg   <= '0;
        end
        else if (adv && ham.valid)
        begin
            best_reg       <= best_next;
            second_reg     <= second_next;
            best_lvl_reg   <= best_lvl_next;
            second_lvl_reg <= second_lvl_next;
            best_idx_reg   <= best_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg <= '0;
        end
        else if (adv)
        begin
            snap_reg.valid    <= snap_valid_next;
            snap_reg.none     <= (best_lvl_next == bhm_pkg::LVL_NONE);
            snap_reg.same_lvl <= (best_lvl_next == second_lvl_next);
            snap_reg.idx      <= best_idx_next;
            snap_reg.best     <= best_next;
            snap_reg.second   <= second_next;
        end
    end

    assign snap = snap_reg;

endmodule
`default_nettype wire

>>> hdl/bhm_judge.sv
// Threshold and ratio test on the captured best pair, and the result register.
// Depends on bhm_pkg.
`default_nettype none
module bhm_judge (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bhm_pkg::snap_t             snap,
    input  wire logic [bhm_pkg::CFG_W-1:0]  accept_threshold,
    input  wire logic [bhm_pkg::CFG_W-1:0]  nn_ratio,
    input  wire logic                       res_ready,
    output logic                            res_valid,
    output bhm_pkg::res_t                   res
);

    logic                res_valid_reg;
    bhm_pkg::res_t       res_reg, res_next;
    logic                load;
    logic [17:0]         lhs;
    logic [17:0]         rhs;

    assign load = !res_valid_reg || res_ready;
    assign lhs  = {1'b0, snap.best, 8'd0};
    assign rhs  = 18'(nn_ratio) * 18'(snap.second);

    always_comb
    begin
        res_next.best_distance   = snap.best;
        res_next.second_distance = snap.second;
        res_next.match_index     = snap.none ? '0 : snap.idx;
        if (snap.none || snap.best > accept_threshold)
        begin
            res_next.status = bhm_pkg::ST_FAR;
        end
        else if (snap.same_lvl && lhs > rhs)
        begin
            res_next.status = bhm_pkg::ST_RATIO;
        end
        else
        begin
            res_next.status = bhm_pkg::ST_MATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= snap.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && snap.valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

>>> hdl/bhm_checker.sv
// Port-level checks for hamming_best_match_ratio_test, attached by bind.
// Depends on bhm_pkg.
`default_nettype none
module bhm_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire logic                       req_ready,
    input  wire bhm_pkg::req_t              req,
    input  wire logic                       res_valid,
    input  wire logic                       res_ready,
    input  wire bhm_pkg::res_t              res,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [bhm_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [bhm_pkg::CFG_W-1:0]  cfg_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.best_distance <= res.second_distance)
        else $error("best distance above second distance");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.best_distance == bhm_pkg::DIST_NONE |->
            res.status == bhm_pkg::ST_FAR && res.match_index == '0
            && res.second_distance == bhm_pkg::DIST_NONE)
        else $error("empty search not reported as too far");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid && !res_ready)
        else $error("request stalled without output backpressure");

endmodule

bind hamming_best_match_ratio_test bhm_checker u_bhm_checker (.*);
`default_nettype wire

>>> dv/tb_hamming_best_match_ratio_test.sv
// Testbench for hamming_best_match_ratio_test: query/candidate requests with a
// built-in tracker of best and second distances checked against every result.
// Depends on bhm_pkg and the hamming_best_match_ratio_test RTL.
`default_nettype none
module tb_hamming_best_match_ratio_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [255:0] ONES = '1;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    bhm_pkg::req_t req;
    logic res_valid;
    logic res_ready;
    bhm_pkg::res_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic [bhm_pkg::CIDX_W-1:0] cfg_index;
    logic [bhm_pkg::CFG_W-1:0] cfg_data;

    // tracker state
    logic [255:0] qry_desc;
    logic [bhm_pkg::DIST_W-1:0] trk_best;
    logic [bhm_pkg::DIST_W-1:0] trk_second;
    logic [bhm_pkg::TLVL_W-1:0] trk_best_lvl;
    logic [bhm_pkg::TLVL_W-1:0] trk_second_lvl;
    logic [bhm_pkg::IDX_W-1:0] trk_best_idx;
    logic [bhm_pkg::CFG_W-1:0] thr_reg;
    logic [bhm_pkg::CFG_W-1:0] ratio_reg;

    bhm_pkg::res_t match_q[$];
    int errors = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    bit hold_req = 1'b0;

    hamming_best_match_ratio_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_tracking();
        trk_best = bhm_pkg::DIST_NONE;
        trk_second = bhm_pkg::DIST_NONE;
        trk_best_lvl = bhm_pkg::LVL_NONE;
        trk_second_lvl = bhm_pkg::LVL_NONE;
        trk_best_idx = '0;
    endfunction

    function automatic void track_request(input bhm_pkg::req_t r);
        logic [bhm_pkg::DIST_W-1:0] d;
        bhm_pkg::res_t e;
        if (r.func == bhm_pkg::FUNC_QUERY)
        begin
            qry_desc = {r.desc_w3, r.desc_w2, r.desc_w1, r.desc_w0};
            clear_tracking();
            return;
        end
        if (!r.cand_excluded)
        begin
            d = bhm_pkg::DIST_W'($countones(qry_desc ^
                                            {r.desc_w3, r.desc_w2, r.desc_w1, r.desc_w0}));
            if (d < trk_best)
            begin
                trk_second = trk_best;
                trk_second_lvl = trk_best_lvl;
                trk_best = d;
                trk_best_lvl = {1'b0, r.cand_level};
                trk_best_idx = r.cand_index;
            end
            else if (d < trk_second)
            begin
                trk_second = d;
                trk_second_lvl = {1'b0, r.cand_level};
            end
        end
        if (!r.last)
            return;
        if (trk_best_lvl == bhm_pkg::LVL_NONE || trk_best > thr_reg)
            e.status = bhm_pkg::ST_FAR;
        else if (trk_best_lvl == trk_second_lvl &&
                 int'(trk_best) * 256 > int'(ratio_reg) * int'(trk_second))
            e.status = bhm_pkg::ST_RATIO;
        else
            e.status = bhm_pkg::ST_MATCH;
        e.match_index = (trk_best_lvl == bhm_pkg::LVL_NONE) ? '0 : trk_best_idx;
        e.best_distance = trk_best;
        e.second_distance = trk_second;
        match_q.insert(match_q.size(), e);
    endfunction

    function automatic bhm_pkg::req_t mk_req(input logic func, input logic [255:0] desc,
                                             input int idx, input int lvl, input bit excl,
                                             input bit last);
        bhm_pkg::req_t r;
        r.func = func;
        {r.desc_w3, r.desc_w2, r.desc_w1, r.desc_w0} = desc;
        r.cand_index = bhm_pkg::IDX_W'(idx);
        r.cand_level = bhm_pkg::LVL_W'(lvl);
        r.cand_excluded = excl;
        r.last = last;
        return r;
    endfunction

    function automatic logic [255:0] flip_low(input logic [255:0] base, input int n);
        return base ^ ((256'd1 << n) - 256'd1);
    endfunction

    function automatic logic [255:0] rand_desc();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [255:0] near_desc(input logic [255:0] base);
        logic [255:0] m;
        int k;
        m = '0;
        case ($urandom_range(3))
            0: k = $urandom_range(0, 24);
            1: k = $urandom_range(25, 130);
            2: return rand_desc();
            default:
            begin
                m = ONES;
                k = $urandom_range(0, 12);
            end
        endcase
        for (int i = 0; i < k; i++)
            m = m ^ (256'd1 << $urandom_range(255));
        return base ^ m;
    endfunction

    task automatic send_req(input bhm_pkg::req_t r);
        @(negedge clk);
        while ($urandom_range(99) < snd_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        track_request(r);
    endtask

    task automatic write_reg(input logic [bhm_pkg::CIDX_W-1:0] idx,
                             input logic [bhm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == bhm_pkg::CFG_ACCEPT_THRESHOLD)
            thr_reg = val;
        else if (idx == bhm_pkg::CFG_NN_RATIO)
            ratio_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input int thr, input int ratio);
        wait_idle();
        write_reg(bhm_pkg::CFG_ACCEPT_THRESHOLD, bhm_pkg::CFG_W'(thr));
        write_reg(bhm_pkg::CFG_NN_RATIO, bhm_pkg::CFG_W'(ratio));
    endtask

    // mostly query + candidate groups, some stray requests
    task automatic run_random(input int n_items);
        int sent;
        int n_cand;
        int grp_lvl;
        int kind;
        logic [255:0] q;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                q = rand_desc();
                send_req(mk_req(bhm_pkg::FUNC_QUERY, q, $urandom_range(1023),
                                $urandom_range(7), $urandom_range(1), $urandom_range(1)));
                n_cand = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
                grp_lvl = $urandom_range(7);
                for (int i = 0; i < n_cand; i++)
                    send_req(mk_req(bhm_pkg::FUNC_CAND, near_desc(q), $urandom_range(1023),
                                    $urandom_range(1) ? grp_lvl : $urandom_range(7),
                                    $urandom_range(99) < 15,
                                    i == n_cand - 1 || $urandom_range(99) < 5));
                sent += n_cand + 1;
            end
            else
            begin
                send_req(mk_req(kind < 93 ? bhm_pkg::FUNC_CAND : bhm_pkg::FUNC_QUERY,
                                rand_desc(), $urandom_range(1023), $urandom_range(7),
                                $urandom_range(1), $urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        logic [255:0] pat;
        pat = {4{64'hA5C3_0F96_3C5A_E1B7}};
        snd_pct = 0;
        rcv_pct = 0;
        // candidate before any query: distance 256 against zero query, nothing found
        send_req(mk_req(bhm_pkg::FUNC_CAND, ONES, 1023, 7, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_QUERY, pat, 0, 0, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 10), 5, 3, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 10), 6, 3, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 10), 7, 3, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 1), 8, 3, 1, 1));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 20), 1023, 2, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_QUERY, ONES, 1023, 7, 1, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(ONES, 50), 1, 1, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(ONES, 60), 2, 4, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_QUERY, pat, 0, 0, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 50), 3, 1, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 60), 4, 1, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 40), 9, 1, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 44), 10, 1, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_QUERY, pat, 0, 0, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 96), 11, 0, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 95), 12, 5, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_QUERY, '0, 0, 0, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, '0, 512, 6, 0, 1));
        send_req(mk_req(bhm_pkg::FUNC_QUERY, pat, 0, 0, 0, 0));
        send_req(mk_req(bhm_pkg::FUNC_CAND, pat, 13, 2, 1, 1));
        send_req(mk_req(bhm_pkg::FUNC_CAND, flip_low(pat, 256), 14, 2, 0, 1));
    endtask

    task automatic test_register_extremes();
        snd_pct = 0;
        rcv_pct = 0;
        set_regs(0, 0);
        run_random(30);
        set_regs(511, 511);
        run_random(30);
        set_regs(256, 256);
        run_random(30);
        set_regs(0, 256);
        run_random(20);
        set_regs(256, 0);
        run_random(20);
    endtask

    task automatic test_random_receiver_slow();
        set_regs($urandom_range(60, 140), $urandom_range(150, 256));
        snd_pct = 18;
        rcv_pct = 88;
        run_random(220);
    endtask

    task automatic test_random_sender_slow();
        set_regs($urandom_range(256), $urandom_range(256));
        snd_pct = 88;
        rcv_pct = 18;
        run_random(180);
    endtask

    task automatic test_random_full_rate();
        set_regs(95, 230);
        snd_pct = 0;
        rcv_pct = 0;
        run_random(170);
    endtask

    task automatic test_backpressure();
        set_regs($urandom_range(80, 200), $urandom_range(180, 256));
        snd_pct = 0;
        rcv_pct = 0;
        hold_req = 1'b1;
        run_random(80);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        qry_desc = '0;
        clear_tracking();
        thr_reg = bhm_pkg::THR_RESET;
        ratio_reg = bhm_pkg::RATIO_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random_receiver_slow();
        test_random_sender_slow();
        test_random_full_rate();
        test_backpressure();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && match_q.size() == 0)
            $display("tb_hamming_best_match_ratio_test: PASS");
        else
            $display("tb_hamming_best_match_ratio_test: FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            res_ready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        bhm_pkg::res_t e;
        if (rst_n && res_valid && res_ready)
        begin
            if (match_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, res);
            end
            else
            begin
                e = match_q.pop_front();
                flag_field("status", int'(e.status), int'(res.status));
                flag_field("match_index", int'(e.match_index), int'(res.match_index));
                flag_field("best_distance", int'(e.best_distance), int'(res.best_distance));
                flag_field("second_distance", int'(e.second_distance),
                           int'(res.second_distance));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("tb_hamming_best_match_ratio_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
